// ===== hdl/difference_alpha_extract_assert.svh =====
// Assertion macros used by the difference alpha extract back end
`ifndef DIFFERENCE_ALPHA_EXTRACT_ASSERT_SVH
`define DIFFERENCE_ALPHA_EXTRACT_ASSERT_SVH

// same-cycle implication
`define DAE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dae_pkg.sv =====
// Package: shared types and constants of the difference alpha extract block
package dae_pkg;
    localparam int MAX_DIM = 4096;
    localparam int CW      = 12;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 88;

    typedef struct packed {
        logic            box;
        logic            chg;
        logic [2:0][7:0] o;
        logic [2:0][7:0] n;
        logic [7:0]      bp;
        logic [8:0]      bq;
        logic            found;
        logic [CW-1:0]   left;
        logic [CW-1:0]   right;
        logic [CW-1:0]   top;
        logic [CW-1:0]   bottom;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage

// ===== hdl/difference_alpha_extract.sv =====
// Top level: difference alpha extract, front end, job queue and back end
// Each accepted pixel is classified combinationally; box-mode pixels that are not last
// produce no result and are taken one per cycle while the two-entry job queue has room.
// Unchanged overlay pixels and box results skip the divider and go straight to output.
// A changed overlay pixel runs four divisions (alpha and three channels) one after
// the other on a single restoring divider that, after a saturation check, resolves
// one quotient bit per cycle; alpha first passes a load state, each channel a multiply
// and a load state; a division that saturates or a channel that comes out zero ends early.
module difference_alpha_extract import dae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // old_red, old_green, old_blue, new_red, new_green, new_blue, row, column
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // alpha, out_red, out_green, out_blue, changed, box_found,
    // box_left, box_right, box_top, box_bottom, zero pad
    output logic [OUT_W-1:0] o_m_tdata
);
    t_q_stat q_stat;
    t_job    push_job, pop_job;
    logic    push, pop;

    assign o_cfg_ready = 1'b1;

    dae_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_stat    (q_stat),
        .o_s_tready  (o_s_tready),
        .o_push      (push),
        .o_job       (push_job)
    );

    dae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    dae_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );
endmodule

// ===== hdl/dae_front.sv =====
// Front end: config register, change classification, best ratio, box tracking
module dae_front import dae_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_data,
    input  logic            i_s_tvalid,
    input  logic [IN_W-1:0] i_s_tdata,
    input  logic            i_s_tlast,
    input  t_q_stat         i_q_stat,
    output logic            o_s_tready,
    output logic            o_push,
    output t_job            o_job
);
    logic            r_mode;
    logic            r_any;
    logic [CW-1:0]   r_minc, r_maxc, r_minr, r_maxr;
    logic [2:0][7:0] o, n, p;
    logic [2:0][8:0] q;
    logic [CW-1:0]   row, col;
    logic            chg, in_box, accept, n_any;
    logic [CW-1:0]   n_minc, n_maxc, n_minr, n_maxr;
    logic [7:0]      bp;
    logic [8:0]      bq;

    assign o[0] = i_s_tdata[7:0];
    assign o[1] = i_s_tdata[15:8];
    assign o[2] = i_s_tdata[23:16];
    assign n[0] = i_s_tdata[31:24];
    assign n[1] = i_s_tdata[39:32];
    assign n[2] = i_s_tdata[47:40];
    assign row  = i_s_tdata[59:48];
    assign col  = i_s_tdata[71:60];

    always_comb begin
        chg = 1'b0;
        bp  = 8'd0;
        bq  = 9'd1;
        for (int i = 0; i < 3; i++) begin
            if (o[i] > n[i]) begin
                p[i] = o[i] - n[i];
                q[i] = {1'b0, o[i]};
            end else begin
                p[i] = n[i] - o[i];
                q[i] = 9'd256 - {1'b0, o[i]};
            end
            if (o[i] != n[i]) chg = 1'b1;
            if (17'(p[i]) * 17'(bq) > 17'(bp) * 17'(q[i])) begin
                bp = p[i];
                bq = q[i];
            end
        end
    end

    assign in_box = chg && (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);

    always_comb begin
        n_any  = r_any;
        n_minc = r_minc;
        n_maxc = r_maxc;
        n_minr = r_minr;
        n_maxr = r_maxr;
        if (in_box) begin
            n_any = 1'b1;
            if (col < r_minc) n_minc = col;
            if (col > r_maxc) n_maxc = col;
            if (row < r_minr) n_minr = row;
            if (row > r_maxr) n_maxr = row;
        end
    end

    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = accept && (!r_mode || i_s_tlast);

    always_comb begin
        o_job        = '0;
        o_job.box    = r_mode;
        o_job.chg    = chg;
        o_job.o      = o;
        o_job.n      = n;
        o_job.bp     = bp;
        o_job.bq     = bq;
        o_job.found  = n_any;
        if (n_any) begin
            o_job.left   = n_minc;
            o_job.right  = n_maxc;
            o_job.top    = n_minr;
            o_job.bottom = n_maxr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_any  <= 1'b0;
            r_minc <= '1;
            r_maxc <= '0;
            r_minr <= '1;
            r_maxr <= '0;
        end else begin
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (accept && r_mode) begin
                if (i_s_tlast) begin
                    r_any  <= 1'b0;
                    r_minc <= '1;
                    r_maxc <= '0;
                    r_minr <= '1;
                    r_maxr <= '0;
                end else begin
                    r_any  <= n_any;
                    r_minc <= n_minc;
                    r_maxc <= n_maxc;
                    r_minr <= n_minr;
                    r_maxr <= n_maxr;
                end
            end
        end
    end
endmodule

// ===== hdl/dae_queue.sv =====
// Two-entry job queue between front end and back end
module dae_queue import dae_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== hdl/dae_back.sv =====
// Back end: sequenced alpha/channel divisions and the output register
`include "difference_alpha_extract_assert.svh"
module dae_back import dae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_stat          i_q_stat,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic [1:0]         r_idx;
    logic signed [19:0] r_x;
    logic [30:0]        r_rem;
    logic [29:0]        r_dsh;
    logic [7:0]         r_quo;
    logic [3:0]         r_cnt;
    logic [3:0][7:0]    r_res;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out;

    logic [1:0]         ch;
    logic [7:0]         co, cn;
    logic signed [9:0]  d;
    logic signed [19:0] x;
    logic [30:0]        num;
    logic [21:0]        den;
    logic               ge;
    logic [7:0]         n_quo;
    logic [OUT_W-1:0]   res_word;

    assign ch = r_idx - 2'd1;
    assign co = r_job.o[ch];
    assign cn = r_job.n[ch];
    assign d  = signed'({2'b0, cn}) - signed'({2'b0, co});
    assign x  = 20'(d * signed'({1'b0, r_job.bq})) + signed'(20'(16'(co) * 16'(r_job.bp)));

    always_comb begin
        if (r_idx == 2'd0) begin
            num = 31'(r_job.bp) * 31'(8'd255);
            den = 22'(r_job.bq);
        end else begin
            num = 31'(r_x[16:0]) * 31'(14'd9999);
            den = 22'(r_job.bp) * 22'(14'd10000);
        end
    end

    assign ge    = r_rem >= {1'b0, r_dsh};
    assign n_quo = {r_quo[6:0], ge};

    always_comb begin
        res_word = '0;
        if (r_job.box) begin
            res_word[33]    = r_job.found;
            res_word[45:34] = r_job.left;
            res_word[57:46] = r_job.right;
            res_word[69:58] = r_job.top;
            res_word[81:70] = r_job.bottom;
        end else if (!r_job.chg) begin
            res_word[15:8]  = r_job.n[0];
            res_word[23:16] = r_job.n[1];
            res_word[31:24] = r_job.n[2];
        end else begin
            res_word[31:0]  = r_res;
            res_word[32]    = 1'b1;
        end
    end

    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (o_pop) begin
                r_job <= i_job;
                r_idx <= 2'd0;
            end
            S_PREP: r_x <= x;
            S_LOAD: begin
                r_rem <= num;
                r_dsh <= {den, 8'd0};
                r_quo <= 8'd0;
                r_cnt <= 4'd0;
                if (r_idx != 2'd0 && r_x <= 0) begin
                    r_res[r_idx] <= 8'd0;
                    r_idx        <= r_idx + 2'd1;
                end
            end
            S_DIV: begin
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd0) begin
                    if (ge) begin
                        r_res[r_idx] <= 8'd255;
                        r_idx        <= r_idx + 2'd1;
                    end
                end else begin
                    if (ge) r_rem <= r_rem - {1'b0, r_dsh};
                    r_quo <= n_quo;
                    if (r_cnt == 4'd8) begin
                        r_res[r_idx] <= n_quo;
                        r_idx        <= r_idx + 2'd1;
                    end
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && (!r_out_valid || i_m_tready)) r_out <= res_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (o_pop) begin
                    r_state <= (i_job.box || !i_job.chg) ? S_DONE : S_LOAD;
                end
                S_PREP: r_state <= S_LOAD;
                S_LOAD: begin
                    if (r_idx != 2'd0 && r_x <= 0) begin
                        r_state <= (r_idx == 2'd3) ? S_DONE : S_PREP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if ((r_cnt == 4'd0 && ge) || r_cnt == 4'd8) begin
                        r_state <= (r_idx == 2'd3) ? S_DONE : S_PREP;
                    end
                end
                S_DONE: if (!r_out_valid || i_m_tready) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DAE_ASSERT_NOW(a_div_count, r_state == S_DIV, r_cnt <= 4'd8, "divider ran past 8 steps")
    `DAE_ASSERT_NOW(a_unchanged_alpha, o_m_tvalid && !o_m_tdata[32], o_m_tdata[7:0] == 8'd0, "alpha set on unchanged result")
    `DAE_ASSERT_NEXT(a_out_drain, o_m_tvalid && i_m_tready && r_state != S_DONE, !o_m_tvalid, "result repeated")
    `DAE_ASSERT_NOW(a_pop_idle, o_pop, r_state == S_IDLE && !i_q_stat.empty, "pop outside idle")
endmodule
